// ===== hdl/rpe_pkg.sv =====
`default_nettype none
package rpe_pkg;

  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned NumGains    = 4;

  localparam logic [31:0] GainReset     = 32'h0001_0000;
  localparam logic [19:0] SpsReset      = 20'd1000;
  localparam logic [7:0]  InvertedRange = 8'd2;
  localparam logic [63:0] Div10Recip    = 64'h0066_6666_6666_6667;
  localparam logic [47:0] PowerMax      = 48'h8000_0000_0000;

  typedef enum logic [2:0] {
    REG_GAIN_V  = 3'd0,
    REG_GAIN_R1 = 3'd1,
    REG_GAIN_R2 = 3'd2,
    REG_GAIN_R3 = 3'd3,
    REG_SPS     = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    OP_MUL  = 3'b001,
    OP_DIV  = 3'b010,
    OP_SQRT = 3'b100
  } op_e;

  typedef enum logic [4:0] {
    ST_VQN = 5'd0,
    ST_VSQ = 5'd1,
    ST_VRT = 5'd2,
    ST_VGN = 5'd3,
    ST_VDV = 5'd4,
    ST_IQN = 5'd5,
    ST_ISQ = 5'd6,
    ST_IRT = 5'd7,
    ST_IGN = 5'd8,
    ST_IDV = 5'd9,
    ST_PQN = 5'd10,
    ST_PSS = 5'd11,
    ST_PNN = 5'd12,
    ST_PDV = 5'd13,
    ST_PG0 = 5'd14,
    ST_PGR = 5'd15,
    ST_PDR = 5'd16,
    ST_EMU = 5'd17,
    ST_EDV = 5'd18
  } step_e;

  typedef struct packed {
    logic [62:0]        sum_v_squared;
    logic signed [31:0] sum_v;
    logic [62:0]        sum_i_squared;
    logic signed [31:0] sum_i;
    logic signed [63:0] sum_vi;
    logic [15:0]        sample_count;
    logic [7:0]         range_index;
  } in_t;

  typedef struct packed {
    logic [31:0]        v_rms;
    logic [31:0]        i_rms;
    logic signed [47:0] active_power;
    logic signed [63:0] energy_total;
    logic               error_flag;
  } out_t;

  typedef struct packed {
    logic  load;
    logic  start;
    logic  capture;
    logic  write;
    step_e step;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic done;
    logic slot_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== hdl/rpe_stream_if.sv =====
`default_nettype none
interface rpe_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/rpe_iter.sv =====
`default_nettype none
module rpe_iter import rpe_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire op_e          op_i,
  input  wire logic [127:0] a_i,
  input  wire logic [63:0]  b_i,
  output logic              done_o,
  output logic [127:0]      res_o
);

  logic         busy_q, busy_d, done_q, done_d;
  op_e          op_q, op_d;
  logic [6:0]   cnt_q, cnt_d;
  logic [127:0] acc_q, acc_d, sh_q, sh_d;
  logic [63:0]  opb_q, opb_d, root_q, root_d;
  logic [65:0]  rem_q, rem_d;

  logic [79:0]  pp;
  logic [64:0]  rem_sh;
  logic         div_ge;
  logic [67:0]  rem_s, trial;
  logic         sqrt_ge;

  always_comb begin
    pp      = sh_q[63:0] * opb_q[15:0];
    rem_sh  = {rem_q[63:0], sh_q[127]};
    div_ge  = rem_sh >= {1'b0, opb_q};
    rem_s   = {rem_q, sh_q[127:126]};
    trial   = {2'b00, root_q, 2'b01};
    sqrt_ge = rem_s >= trial;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    sh_d   = sh_q;
    opb_d  = opb_q;
    root_d = root_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      op_d   = op_i;
      sh_d   = a_i;
      opb_d  = b_i;
      acc_d  = '0;
      root_d = '0;
      rem_d  = '0;
      case (op_i)
        OP_MUL:  cnt_d = 7'd3;
        OP_DIV:  cnt_d = 7'd127;
        OP_SQRT: cnt_d = 7'd63;
        default: cnt_d = 7'd0;
      endcase
    end else if (busy_q) begin
      case (op_q)
        OP_MUL: begin
          acc_d = (acc_q >> 16) + {pp, 48'd0};
          opb_d = opb_q >> 16;
        end
        OP_DIV: begin
          rem_d = {2'b00, div_ge ? 64'(rem_sh - {1'b0, opb_q}) : rem_sh[63:0]};
          acc_d = {acc_q[126:0], div_ge};
          sh_d  = sh_q << 1;
        end
        OP_SQRT: begin
          rem_d  = sqrt_ge ? 66'(rem_s - trial) : rem_s[65:0];
          root_d = {root_q[62:0], sqrt_ge};
          sh_d   = sh_q << 2;
        end
        default: ;
      endcase
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    sh_q   <= sh_d;
    opb_q  <= opb_d;
    root_q <= root_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign res_o  = (op_q == OP_SQRT) ? {64'd0, root_q} : acc_q;

endmodule
`default_nettype wire

// ===== hdl/rpe_dp.sv =====
`default_nettype none
module rpe_dp import rpe_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  output sts_t             sts_o,
  input  wire in_t         in_data_i,
  input  wire logic [31:0] gain_i [NumGains],
  input  wire logic [19:0] sps_i,
  input  wire logic        out_ready_i,
  output logic             out_valid_o,
  output out_t             out_data_o
);

  in_t                item_q;
  logic [127:0]       x_q, y_q;
  logic               neg_q;
  logic [31:0]        v_rms_q, i_rms_q;
  logic signed [47:0] power_q;
  logic signed [63:0] energy_q;
  logic               out_valid_q;
  out_t               out_q;

  logic         err_w;
  logic [63:0]  n64, g0, gr, abs_sv, abs_si, abs_pv, sv64, si64, sps64, n_cur;
  op_e          op;
  logic [127:0] opa, res, d_pss;
  logic [63:0]  opb;
  logic         done;

  logic [31:0]  sat32;
  logic [63:0]  sat64, sat_p1, dmag;
  logic         p2_gt, neg_f;
  logic [47:0]  p2;
  logic signed [63:0] delta;
  logic signed [64:0] esum;
  logic signed [63:0] e_next;

  always_comb begin
    err_w  = (item_q.range_index >= 8'(NumGains)) || (item_q.sample_count == 16'd0);
    n64    = {48'd0, item_q.sample_count};
    n_cur  = (n64 << 19) + (n64 << 17);
    g0     = {32'd0, gain_i[0]};
    gr     = {32'd0, gain_i[item_q.range_index[1:0]]};
    sv64   = {{32{item_q.sum_v[31]}}, item_q.sum_v};
    si64   = {{32{item_q.sum_i[31]}}, item_q.sum_i};
    abs_sv = item_q.sum_v[31] ? -sv64 : sv64;
    abs_si = item_q.sum_i[31] ? -si64 : si64;
    abs_pv = item_q.sum_vi[63] ? -item_q.sum_vi : item_q.sum_vi;
    sps64  = (sps_i == 20'd0) ? 64'd1 : {44'd0, sps_i};
  end

  // The final power step divides by 2^16 with a shift and by ten with a
  // reciprocal multiply; anything at or above 2^70 saturates regardless.
  always_comb begin
    op  = OP_MUL;
    opa = '0;
    opb = '0;
    case (cmd_i.step)
      ST_VQN: begin opa = {65'd0, item_q.sum_v_squared}; opb = n64; end
      ST_VSQ: begin opa = {64'd0, abs_sv}; opb = abs_sv; end
      ST_VRT: begin op = OP_SQRT; opa = x_q[127] ? '0 : x_q << (2 * FRAC_BITS); end
      ST_VGN: begin opa = {64'd0, x_q[63:0]}; opb = g0; end
      ST_VDV: begin op = OP_DIV; opa = x_q; opb = n64 << 16; end
      ST_IQN: begin opa = {65'd0, item_q.sum_i_squared}; opb = n64; end
      ST_ISQ: begin opa = {64'd0, abs_si}; opb = abs_si; end
      ST_IRT: begin op = OP_SQRT; opa = x_q[127] ? '0 : x_q << (2 * FRAC_BITS); end
      ST_IGN: begin opa = {64'd0, x_q[63:0]}; opb = gr; end
      ST_IDV: begin op = OP_DIV; opa = x_q; opb = n_cur; end
      ST_PQN: begin opa = {64'd0, abs_pv}; opb = n64; end
      ST_PSS: begin opa = {64'd0, abs_sv}; opb = abs_si; end
      ST_PNN: begin opa = {64'd0, n64}; opb = n64; end
      ST_PDV: begin op = OP_DIV; opa = x_q << FRAC_BITS; opb = y_q[63:0]; end
      ST_PG0: begin opa = {64'd0, x_q[63:0]}; opb = g0; end
      ST_PGR: begin opa = {64'd0, x_q[63:0]}; opb = gr; end
      ST_PDR: begin opa = {74'd0, x_q[69:16]}; opb = Div10Recip; end
      ST_EMU: begin opa = {64'd0, x_q[63:0]}; opb = n64; end
      ST_EDV: begin op = OP_DIV; opa = x_q; opb = sps64; end
      default: ;
    endcase
  end

  rpe_iter u_iter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start),
    .op_i    (op),
    .a_i     (opa),
    .b_i     (opb),
    .done_o  (done),
    .res_o   (res)
  );

  always_comb begin
    sat32  = (|res[127:32]) ? '1 : res[31:0];
    sat64  = (|res[127:64]) ? '1 : res[63:0];
    sat_p1 = (|res[127:80]) ? '1 : res[79:16];
    d_pss  = (item_q.sum_v[31] ^ item_q.sum_i[31]) ? x_q + res : x_q - res;
    p2_gt  = (|x_q[127:70]) || (|res[127:106]) || (res[105] && (|res[104:58]));
    p2     = p2_gt ? PowerMax : res[105:58];
    neg_f  = neg_q ^ (item_q.range_index == InvertedRange);
    if (!neg_f && (p2 == PowerMax)) begin
      p2 = PowerMax - 48'd1;
    end
    dmag   = res[63:0];
    delta  = neg_q ? -dmag : dmag;
    esum   = {energy_q[63], energy_q} + {delta[63], delta};
    e_next = (esum[64] != esum[63]) ? {esum[64], {63{~esum[64]}}} : esum[63:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (cmd_i.capture) begin
      case (cmd_i.step)
        ST_VQN, ST_IQN, ST_VRT, ST_IRT, ST_VGN, ST_IGN, ST_PGR, ST_EMU: x_q <= res;
        ST_VSQ, ST_ISQ: x_q <= x_q - res;
        ST_VDV: v_rms_q <= sat32;
        ST_IDV: i_rms_q <= sat32;
        ST_PQN: x_q <= item_q.sum_vi[63] ? -res : res;
        ST_PSS: begin
          neg_q <= d_pss[127];
          x_q   <= d_pss[127] ? -d_pss : d_pss;
        end
        ST_PNN: y_q <= res;
        ST_PDV: x_q <= {64'd0, sat64};
        ST_PG0: x_q <= {64'd0, sat_p1};
        ST_PDR: begin
          neg_q   <= neg_f;
          x_q     <= {80'd0, p2};
          power_q <= neg_f ? -p2 : p2;
        end
        default: ;
      endcase
    end
    if (cmd_i.write) begin
      if (err_w) begin
        out_q <= '{v_rms: '0, i_rms: '0, active_power: '0, energy_total: '0,
                   error_flag: 1'b1};
      end else begin
        out_q <= '{v_rms: v_rms_q, i_rms: i_rms_q, active_power: power_q,
                   energy_total: energy_q, error_flag: 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      energy_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.capture && (cmd_i.step == ST_EDV)) begin
        energy_q <= e_next;
      end
      if (cmd_i.write) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o       = '{err: err_w, done: done, slot_free: !out_valid_q || out_ready_i};
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_err_keeps_energy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.write && err_w) |=> $stable(energy_q))
    else $error("energy changed on a rejected item");
  a_err_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.write && err_w) |=> (out_q.error_flag && (out_q.v_rms == '0)
                                && (out_q.energy_total == '0)))
    else $error("rejected item produced a nonzero result");
  a_write_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write |-> (!out_valid_q || out_ready_i))
    else $error("result written over a pending item");
`endif

endmodule
`default_nettype wire

// ===== hdl/rpe_ctrl.sv =====
`default_nettype none
module rpe_ctrl import rpe_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_WRITE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  step_e  step_q, step_d;
  logic   load, start, capture, write;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    load    = 1'b0;
    start   = 1'b0;
    capture = 1'b0;
    write   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          load    = 1'b1;
          step_d  = ST_VQN;
          state_d = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (sts_i.err) begin
          state_d = S_WRITE;
        end else begin
          start   = 1'b1;
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (sts_i.done) begin
          capture = 1'b1;
          if (step_q == ST_EDV) begin
            state_d = S_WRITE;
          end else begin
            step_d  = step_e'(step_q + 5'd1);
            state_d = S_ISSUE;
          end
        end
      end
      S_WRITE: begin
        if (sts_i.slot_free) begin
          write   = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= ST_VQN;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign cmd_o      = '{load: load, start: start, capture: capture, write: write,
                        step: step_q};

`ifndef SYNTHESIS
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.done |-> (state_q == S_WAIT))
    else $error("unit finished outside of a wait");
  a_no_start_on_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> !sts_i.err)
    else $error("work started on a rejected item");
  a_load_then_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> ((state_q == S_ISSUE) && (step_q == ST_VQN)))
    else $error("item load did not start the sequence");
`endif

endmodule
`default_nettype wire

// ===== hdl/rms_power_energy_from_sums.sv =====
// Channel   Direction  Payload
// in_i      sink       interval sums, sample count, range index
// out_o     source     v_rms, i_rms, active_power, energy_total, error_flag
// APB       slave      gains and samples per second, read and write
//
// A valid item takes its steps on the shared bit-serial unit:
// four 128-step divisions, two 64-step square roots and thirteen 4-step multiplies.
// A rejected item skips the unit. One item is worked on at a time.
// A finished item waits in the output register while the next item is taken.
// Reset clears the energy accumulator and loads the default register values.
`default_nettype none
module rms_power_energy_from_sums import rpe_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  rpe_stream_if.sink       in_i,
  rpe_stream_if.source     out_o,
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic [4:0]  paddr_i,
  input  wire logic [31:0] pwdata_i,
  output logic [31:0]      prdata_o,
  output logic             pready_o
);

  logic [31:0] gain_q [NumGains];
  logic [19:0] sps_q;
  logic        wr_en;
  reg_idx_e    reg_idx;
  cmd_t        cmd;
  sts_t        sts;
  logic        out_valid;
  out_t        out_data;

  assign reg_idx  = reg_idx_e'(paddr_i[4:2]);
  assign wr_en    = psel_i && penable_i && pwrite_i;
  assign pready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumGains; k++) begin
        gain_q[k] <= GainReset;
      end
      sps_q <= SpsReset;
    end else if (wr_en) begin
      case (reg_idx)
        REG_GAIN_V:  gain_q[0] <= pwdata_i;
        REG_GAIN_R1: gain_q[1] <= pwdata_i;
        REG_GAIN_R2: gain_q[2] <= pwdata_i;
        REG_GAIN_R3: gain_q[3] <= pwdata_i;
        REG_SPS:     sps_q     <= pwdata_i[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GAIN_V:  prdata_o = gain_q[0];
      REG_GAIN_R1: prdata_o = gain_q[1];
      REG_GAIN_R2: prdata_o = gain_q[2];
      REG_GAIN_R3: prdata_o = gain_q[3];
      REG_SPS:     prdata_o = {12'd0, sps_q};
      default:     prdata_o = '0;
    endcase
  end

  rpe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rpe_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_i.data),
    .gain_i      (gain_q),
    .sps_i       (sps_q),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .out_data_o  (out_data)
  );

  assign out_o.valid = out_valid;
  assign out_o.data  = out_data;

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rpe_pkg::*;

  localparam int unsigned Frac = 16;
  localparam int unsigned NumRandom = 1050;
  localparam longint unsigned CycleLimit = 64'd20_000_000;
  localparam int unsigned DrainCycles = 1000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel_i = 1'b0;
  logic penable_i = 1'b0;
  logic pwrite_i = 1'b0;
  logic [4:0] paddr_i = '0;
  logic [31:0] pwdata_i = '0;
  logic [31:0] prdata_o;
  logic pready_o;

  rpe_stream_if #(.T(in_t)) in_ch ();
  rpe_stream_if #(.T(out_t)) out_ch ();

  rms_power_energy_from_sums dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_i(in_ch.sink),
    .out_o(out_ch.source),
    .psel_i(psel_i),
    .penable_i(penable_i),
    .pwrite_i(pwrite_i),
    .paddr_i(paddr_i),
    .pwdata_i(pwdata_i),
    .prdata_o(prdata_o),
    .pready_o(pready_o)
  );

  always #10 clk_i = ~clk_i;

  logic [31:0] gain_q [4];
  logic [19:0] sps_q;
  logic signed [63:0] energy_q;
  out_t readings_due [$];
  int unsigned error_count = 0;
  longint unsigned cycle_count = 0;
  bit sink_hold = 1'b0;
  bit sink_quiet = 1'b0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  function automatic logic [63:0] root128(logic [127:0] x);
    logic [63:0] res;
    logic [63:0] c;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      c = res | (64'd1 << b);
      if (x >= 128'(c) * 128'(c)) res = c;
    end
    return res;
  endfunction

  function automatic logic [31:0] rms_of(logic [62:0] q, logic signed [31:0] a,
                                         logic [15:0] n, logic [31:0] gain,
                                         logic [63:0] div);
    logic signed [129:0] d;
    logic [127:0] r;
    logic [127:0] v;
    d = $signed({67'd0, q}) * $signed({114'd0, n}) - 130'(a) * 130'(a);
    if (d < 0) return 32'd0;
    r = 128'(root128(128'(d) << (2 * Frac)));
    v = (r * 128'(gain)) / (128'(n) * 128'd65536 * 128'(div));
    return (v > 128'hffff_ffff) ? 32'hffff_ffff : v[31:0];
  endfunction

  function automatic logic [63:0] clip64(logic [127:0] x, logic [63:0] lim);
    return (x > 128'(lim)) ? lim : x[63:0];
  endfunction

  function automatic out_t meter_reading(in_t it);
    out_t o;
    logic signed [129:0] dp;
    logic [127:0] mag;
    logic [63:0] c, p1, p2, dmag, sps, gr;
    logic [63:0] nn;
    logic neg;
    logic signed [63:0] delta, e;
    o = '0;
    if (it.range_index > 8'd3 || it.sample_count == 16'd0) begin
      o.error_flag = 1'b1;
      return o;
    end
    gr = 64'(gain_q[it.range_index[1:0]]);
    o.v_rms = rms_of(it.sum_v_squared, it.sum_v, it.sample_count, gain_q[0], 64'd1);
    o.i_rms = rms_of(it.sum_i_squared, it.sum_i, it.sample_count, gr[31:0], 64'd10);
    dp = 130'(it.sum_vi) * $signed({114'd0, it.sample_count})
         - 130'(it.sum_v) * 130'(it.sum_i);
    neg = dp < 0;
    mag = neg ? 128'(-dp) : 128'(dp);
    nn = 64'(it.sample_count) * 64'(it.sample_count);
    c = clip64((mag << Frac) / 128'(nn), 64'hffff_ffff_ffff_ffff);
    p1 = clip64((128'(c) * 128'(gain_q[0])) / 128'd65536, 64'hffff_ffff_ffff_ffff);
    p2 = clip64((128'(p1) * 128'(gr)) / 128'd655360, 64'h8000_0000_0000);
    if (it.range_index == InvertedRange) neg = ~neg;
    if (!neg && p2 == 64'h8000_0000_0000) p2 = p2 - 64'd1;
    o.active_power = neg ? 48'(-p2) : p2[47:0];
    sps = (sps_q == 20'd0) ? 64'd1 : 64'(sps_q);
    dmag = (p2 * 64'(it.sample_count)) / sps;
    delta = neg ? -$signed(dmag) : $signed(dmag);
    e = energy_q;
    if (delta > 0 && e > 64'sh7fff_ffff_ffff_ffff - delta) e = 64'sh7fff_ffff_ffff_ffff;
    else if (delta < 0 && e < $signed(64'h8000_0000_0000_0000) - delta)
      e = $signed(64'h8000_0000_0000_0000);
    else e = e + delta;
    energy_q = e;
    o.energy_total = e;
    return o;
  endfunction

  task automatic apb_write(reg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    psel_i <= 1'b1;
    pwrite_i <= 1'b1;
    paddr_i <= 5'(idx) << 2;
    pwdata_i <= val;
    @(negedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    while (!pready_o) @(posedge clk_i);
    @(negedge clk_i);
    psel_i <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i <= 1'b0;
    if (idx == REG_SPS) sps_q = val[19:0];
    else gain_q[2'(idx)] = val;
  endtask

  task automatic apb_write_raw(logic [4:0] addr, logic [31:0] val);
    @(negedge clk_i);
    psel_i <= 1'b1;
    pwrite_i <= 1'b1;
    paddr_i <= addr;
    pwdata_i <= val;
    @(negedge clk_i);
    penable_i <= 1'b1;
    @(negedge clk_i);
    psel_i <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (readings_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic source_gap();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 40) return;
    if (k < 95) repeat ($urandom_range(1, 4)) @(negedge clk_i);
    else repeat ($urandom_range(50, 2000)) @(negedge clk_i);
  endtask

  task automatic send_interval(in_t it, bit gaps, bit check_typed, out_t typed);
    out_t p;
    if (gaps) source_gap();
    @(negedge clk_i);
    in_ch.data <= it;
    in_ch.valid <= 1'b1;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    p = meter_reading(it);
    if (check_typed && p != typed) begin
      $display("%0t predictor disagrees with table: exp %h got %h", $time, typed, p);
      error_count++;
    end
    readings_due.push_back(p);
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic in_t sine_like(bit noisy);
    in_t it;
    logic [15:0] n;
    longint amp_v, amp_i, mv, mi;
    n = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535))
                                     : 16'($urandom_range(1, 2000));
    amp_v = $urandom_range(0, 30000);
    amp_i = $urandom_range(0, 30000);
    mv = $signed(32'($urandom_range(0, 2000))) - 1000;
    mi = $signed(32'($urandom_range(0, 2000))) - 1000;
    it.sample_count = n;
    it.range_index = 8'($urandom_range(0, 3));
    it.sum_v = 32'(mv * longint'(n));
    it.sum_i = 32'(mi * longint'(n));
    it.sum_v_squared = 63'((amp_v * amp_v + mv * mv) * longint'(n));
    it.sum_i_squared = 63'((amp_i * amp_i + mi * mi) * longint'(n));
    it.sum_vi = (($signed(64'($urandom_range(0, 2 * 30000))) - 30000)
                 * $signed(64'($urandom_range(0, 30000))) + mv * mi) * longint'(n);
    if (noisy) begin
      case ($urandom_range(0, 5))
        0: it.sum_v_squared = 63'(rand64());
        1: it.sum_i_squared = 63'(rand64());
        2: it.sum_vi = rand64();
        3: it.sum_v = $urandom();
        4: it.sum_i = $urandom();
        default: it.range_index = 8'($urandom());
      endcase
      if ($urandom_range(0, 7) == 0) it.sample_count = 16'd0;
    end
    return it;
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t timeout", $time);
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_t exp_r;
    if (out_ch.valid && out_ch.ready) begin
      if (readings_due.size() == 0) begin
        $display("%0t unexpected item: got %h", $time, out_ch.data);
        error_count++;
      end else begin
        exp_r = readings_due.pop_front();
        if (out_ch.data.v_rms !== exp_r.v_rms)
          $display("%0t v_rms exp %h got %h", $time, exp_r.v_rms, out_ch.data.v_rms);
        if (out_ch.data.i_rms !== exp_r.i_rms)
          $display("%0t i_rms exp %h got %h", $time, exp_r.i_rms, out_ch.data.i_rms);
        if (out_ch.data.active_power !== exp_r.active_power)
          $display("%0t active_power exp %h got %h", $time, exp_r.active_power,
                   out_ch.data.active_power);
        if (out_ch.data.energy_total !== exp_r.energy_total)
          $display("%0t energy_total exp %h got %h", $time, exp_r.energy_total,
                   out_ch.data.energy_total);
        if (out_ch.data.error_flag !== exp_r.error_flag)
          $display("%0t error_flag exp %b got %b", $time, exp_r.error_flag,
                   out_ch.data.error_flag);
        if (out_ch.data !== exp_r) error_count++;
      end
    end
  end

  always @(negedge clk_i) begin
    int unsigned k;
    if (sink_hold || sink_quiet) begin
      out_ch.ready <= sink_hold ? 1'b0 : 1'b1;
    end else begin
      k = $urandom_range(0, 99);
      out_ch.ready <= (k >= 30);
      if (k < 2) repeat ($urandom_range(20, 1500)) @(negedge clk_i);
    end
  end

  typedef struct {
    in_t it;
    bit typed;
    out_t res;
  } stim_row_t;

  initial begin
    stim_row_t rows [$];
    stim_row_t row;
    in_t it;
    out_t zero_err;
    zero_err = '0;
    zero_err.error_flag = 1'b1;
    for (int g = 0; g < 4; g++) gain_q[g] = GainReset;
    sps_q = SpsReset;
    energy_q = '0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    it = '0;
    it.sample_count = 16'd1;
    row.it = it; row.typed = 1'b1; row.res = '0; rows.push_back(row);
    it = '0;
    row.it = it; row.typed = 1'b1; row.res = zero_err; rows.push_back(row);
    it.sample_count = 16'd5; it.range_index = 8'd4;
    row.it = it; row.res = zero_err; rows.push_back(row);
    it.range_index = 8'hff; it.sum_v_squared = '1;
    row.it = it; row.res = zero_err; rows.push_back(row);
    row.typed = 1'b0;
    for (int r = 0; r < 4; r++) begin
      it = '0;
      it.sample_count = 16'd4; it.range_index = 8'(r);
      it.sum_v_squared = 63'd400; it.sum_i_squared = 63'd100; it.sum_vi = 64'sd150;
      row.it = it; rows.push_back(row);
    end
    it = '0; it.sample_count = 16'd10; it.sum_v = 32'sd1000; it.sum_v_squared = 63'd5;
    it.sum_i = -32'sd1000;
    row.it = it; rows.push_back(row);
    it = '0; it.sample_count = 16'hffff; it.range_index = 8'd3;
    it.sum_v_squared = '1; it.sum_i_squared = '1;
    it.sum_v = 32'sh8000_0000; it.sum_i = 32'sh7fff_ffff;
    it.sum_vi = 64'sh7fff_ffff_ffff_ffff;
    row.it = it; rows.push_back(row);
    it.sum_vi = 64'sh8000_0000_0000_0000; it.range_index = 8'd2;
    row.it = it; rows.push_back(row);
    it = '0; it.sample_count = 16'd1; it.sum_vi = 64'sh7fff_ffff_ffff_ffff;
    it.sum_v_squared = '1; it.sum_i_squared = '1;
    for (int k = 0; k < 4; k++) begin
      row.it = it; rows.push_back(row);
    end
    it.sum_vi = 64'sh8000_0000_0000_0000;
    for (int k = 0; k < 8; k++) begin
      row.it = it; rows.push_back(row);
    end

    foreach (rows[i]) send_interval(rows[i].it, 1'b0, rows[i].typed, rows[i].res);
    wait_idle();

    apb_write(REG_GAIN_V, 32'hffff_ffff);
    apb_write(REG_GAIN_R1, 32'hffff_ffff);
    apb_write(REG_GAIN_R2, 32'hffff_ffff);
    apb_write(REG_GAIN_R3, 32'hffff_ffff);
    apb_write(REG_SPS, 32'd1);
    apb_write_raw(5'd28, 32'h1234_5678);
    for (int k = 0; k < 12; k++) begin
      it = sine_like(1'b0);
      it.sum_vi = (k % 2 == 0) ? 64'sh7fff_ffff_ffff_ffff : 64'sh8000_0000_0000_0000;
      it.sum_v_squared = '1;
      it.sum_i_squared = '1;
      send_interval(it, 1'b1, 1'b0, zero_err);
    end
    wait_idle();
    apb_write(REG_SPS, 32'd0);
    apb_write(REG_GAIN_V, 32'd0);
    apb_write(REG_GAIN_R2, 32'd0);
    for (int k = 0; k < 6; k++) send_interval(sine_like(1'b0), 1'b1, 1'b0, zero_err);
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      apb_write(REG_GAIN_V, (ph == 3) ? 32'hffff_ffff : 32'($urandom_range(32768, 200000)));
      apb_write(REG_GAIN_R1, $urandom());
      apb_write(REG_GAIN_R2, 32'($urandom_range(0, 1000000)));
      apb_write(REG_GAIN_R3, (ph == 1) ? 32'd0 : $urandom());
      apb_write(REG_SPS, (ph == 2) ? 32'd1_000_000 : 32'($urandom_range(1, 1000000)));
      if (ph == 1) begin
        sink_hold = 1'b1;
        fork
          begin
            repeat (6000) @(negedge clk_i);
            sink_hold = 1'b0;
          end
          for (int k = 0; k < 8; k++) send_interval(sine_like(1'b0), 1'b0, 1'b0, zero_err);
        join
      end
      if (ph == 2) sink_quiet = 1'b1;
      for (int k = 0; k < NumRandom / 4; k++)
        send_interval(sine_like($urandom_range(0, 4) == 0), ph != 2, 1'b0, zero_err);
      sink_quiet = 1'b0;
      wait_idle();
    end

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/rpe_pkg.sv
hdl/rpe_stream_if.sv
hdl/rpe_iter.sv
hdl/rpe_dp.sv
hdl/rpe_ctrl.sv
hdl/rms_power_energy_from_sums.sv
tb/tb.sv
